[src/qpar_pkg.sv]
// Package: constants, types and the cross-product term table for the peak angular rate block.
`default_nettype none
package qpar_pkg;

  localparam int QW = 16;                 // quaternion component width
  localparam int DW = QW + 1;             // difference width
  localparam int MW = 33;                 // shared multiplier operand width
  localparam int VW = 33;                 // vector part width
  localparam int NW = 35;                 // scaled numerator / quotient width
  localparam int TW = 16;                 // interval width
  localparam int PW = 32;                 // peak width

  localparam logic signed [QW-1:0] QMAX = 16'sd16384;
  localparam logic signed [QW-1:0] QMIN = -16'sd16384;
  localparam logic [MW-1:0] US_PER_S = 33'd1000000;
  localparam int SCALE_SHIFT = 17;
  localparam int MAC_TERMS = 12;
  localparam int SQRT_STEPS = 32;

  // Sequencer state codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_MAC   = 3'd2;
  localparam logic [2:0] ST_SQ    = 3'd3;
  localparam logic [2:0] ST_SQRT  = 3'd4;
  localparam logic [2:0] ST_SCALE = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  // Run position codes
  localparam logic [1:0] POS_START = 2'd0;
  localparam logic [1:0] POS_ONE   = 2'd1;
  localparam logic [1:0] POS_MANY  = 2'd2;

  // Rate jobs
  localparam logic JOB_HELD = 1'b0;   // sample held from earlier items
  localparam logic JOB_LAST = 1'b1;   // backward difference at end of run

  typedef logic signed [QW-1:0] quat_t [4];
  typedef logic signed [DW-1:0] diff_t [4];

  typedef struct packed {
    logic [1:0] qi;
    logic [1:0] di;
    logic       neg;
  } term_t;

  // Term k of Im(conj(q)*d): vector part k/4, term k%4.
  function automatic term_t mac_term(input logic [3:0] k);
    term_t t;
    t.qi = k[1:0];
    case (k)
      4'd0:  begin t.di = 2'd1; t.neg = 1'b0; end
      4'd1:  begin t.di = 2'd0; t.neg = 1'b1; end
      4'd2:  begin t.di = 2'd3; t.neg = 1'b1; end
      4'd3:  begin t.di = 2'd2; t.neg = 1'b0; end
      4'd4:  begin t.di = 2'd2; t.neg = 1'b0; end
      4'd5:  begin t.di = 2'd3; t.neg = 1'b0; end
      4'd6:  begin t.di = 2'd0; t.neg = 1'b1; end
      4'd7:  begin t.di = 2'd1; t.neg = 1'b1; end
      4'd8:  begin t.di = 2'd3; t.neg = 1'b0; end
      4'd9:  begin t.di = 2'd2; t.neg = 1'b1; end
      4'd10: begin t.di = 2'd1; t.neg = 1'b0; end
      4'd11: begin t.di = 2'd0; t.neg = 1'b1; end
      default: begin t.di = 2'd0; t.neg = 1'b0; end
    endcase
    return t;
  endfunction

  function automatic logic signed [QW-1:0] clampq(input logic signed [QW-1:0] v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

endpackage
`default_nettype wire

[src/quaternion_peak_angular_rate_top.sv]
// Top level: peak angular rate over a run of orientation quaternions.
//
//  Channel | Ports                                         | Direction
//  --------+-----------------------------------------------+----------
//  in      | in_valid, in_stall, in_quat_w/x/y/z,          | into block
//          | in_interval_us, in_last_sample                |
//  out     | out_valid, out_stall, out_peak_rate,          | out of block
//          | out_run_too_short                             |
//
// One shared 33x33 signed multiplier plus adders and comparators run under a
// sequencer. One rate passes through the setup, MAC, square, root, scale and
// divide states and then a fold, in that order; no new item is taken until an
// item needing one rate is folded in, and a closing item with held samples
// needs two rates and a hand-off before the block is idle again.
// The first sample of a run only shifts state; a single-sample run goes
// straight to the result hand-off.
// in_stall is high while a rate is being worked or a result is pending.
// Synchronous active-low reset clears the run state and the output valid.
// A result waits in the output register under out_stall while new items
// are still accepted; a finished result waits until that register is free.
`default_nettype none
module quaternion_peak_angular_rate_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire logic signed [qpar_pkg::QW-1:0] in_quat_w,
  input  wire logic signed [qpar_pkg::QW-1:0] in_quat_x,
  input  wire logic signed [qpar_pkg::QW-1:0] in_quat_y,
  input  wire logic signed [qpar_pkg::QW-1:0] in_quat_z,
  input  wire logic [qpar_pkg::TW-1:0]        in_interval_us,
  input  wire logic                           in_last_sample,
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      logic [qpar_pkg::PW-1:0]        out_peak_rate,
  output      logic                           out_run_too_short
);
  import qpar_pkg::*;

  // Run state
  logic [2:0]  state_r, state_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic        job_r, job_nxt;
  logic signed [QW-1:0] cur_r [4];
  logic signed [QW-1:0] p1_r [4];
  logic signed [QW-1:0] p2_r [4];
  logic signed [QW-1:0] cur_nxt [4];
  logic signed [QW-1:0] p1_nxt [4];
  logic signed [QW-1:0] p2_nxt [4];
  logic [TW-1:0] dt_r, dt_nxt, pdt_r, pdt_nxt, p2dt_r, p2dt_nxt;
  logic        last_r, last_nxt;
  logic [PW-1:0] peak_r, peak_nxt;

  // Datapath registers
  logic signed [QW-1:0] q_r [4];
  logic signed [DW-1:0] d_r [4];
  logic signed [QW-1:0] q_nxt [4];
  logic signed [DW-1:0] d_nxt [4];
  logic [DW-1:0] den_r, den_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic signed [VW:0]   acc_r, acc_nxt;
  logic signed [VW-1:0] v_r [3];
  logic signed [VW-1:0] v_nxt [3];
  logic [63:0] n_r, n_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic [NW-1:0] num_r, num_nxt;
  logic [DW-1:0] rem_r, rem_nxt;

  // Output register and pending result
  logic          out_valid_r, out_valid_nxt;
  logic [PW-1:0] out_peak_r, out_peak_nxt, pend_peak_r, pend_peak_nxt;
  logic          out_short_r, out_short_nxt, pend_short_r, pend_short_nxt;

  // Shared multiplier
  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [2*MW-1:0] mul_p;
  assign mul_p = mul_a * mul_b;

  term_t term;
  logic [VW-2:0] vabs;
  logic [63:0]   trial;
  logic [DW:0]   rem_sh;
  logic [PW-1:0] rate_sat;
  logic [TW-1:0] job_dt;
  logic [DW-1:0] dt_nz;
  logic          in_xfer;

  assign in_stall  = (state_r != ST_IDLE) || out_valid_r && (state_r == ST_DONE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_peak_rate     = out_peak_r;
  assign out_run_too_short = out_short_r;

  assign term  = mac_term(cnt_r[3:0]);
  assign vabs  = (VW-1)'(v_r[cnt_r[1:0]][VW-1] ? -v_r[cnt_r[1:0]] : v_r[cnt_r[1:0]]);
  assign trial = res_r + bit_r;
  assign rem_sh = {rem_r, num_r[NW-1]};
  assign rate_sat = (num_r[NW-1:PW] != '0) ? '1 : num_r[PW-1:0];
  assign job_dt = (job_r == JOB_LAST) ? dt_r : ((pos_r == POS_MANY) ? p2dt_r : pdt_r);
  assign dt_nz  = (job_dt == '0) ? DW'(1) : DW'(job_dt);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_MAC: begin
        mul_a = MW'(q_r[term.qi]);
        mul_b = MW'(d_r[term.di]);
      end
      ST_SQ: begin
        mul_a = MW'({1'b0, vabs});
        mul_b = MW'({1'b0, vabs});
      end
      ST_SCALE: begin
        mul_a = MW'({1'b0, res_r[31:0]});
        mul_b = US_PER_S;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;   pos_nxt = pos_r;     job_nxt = job_r;
    cur_nxt = cur_r;       p1_nxt = p1_r;       p2_nxt = p2_r;
    dt_nxt = dt_r;         pdt_nxt = pdt_r;     p2dt_nxt = p2dt_r;
    last_nxt = last_r;     peak_nxt = peak_r;
    q_nxt = q_r;           d_nxt = d_r;         den_nxt = den_r;
    cnt_nxt = cnt_r;       acc_nxt = acc_r;     v_nxt = v_r;
    n_nxt = n_r;           res_nxt = res_r;     bit_nxt = bit_r;
    num_nxt = num_r;       rem_nxt = rem_r;
    out_valid_nxt = out_valid_r;  out_peak_nxt = out_peak_r;
    out_short_nxt = out_short_r;  pend_peak_nxt = pend_peak_r;
    pend_short_nxt = pend_short_r;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          cur_nxt[0] = clampq(in_quat_w);
          cur_nxt[1] = clampq(in_quat_x);
          cur_nxt[2] = clampq(in_quat_y);
          cur_nxt[3] = clampq(in_quat_z);
          dt_nxt   = in_interval_us;
          last_nxt = in_last_sample;
          job_nxt  = JOB_HELD;
          if (pos_r != POS_START) begin
            state_nxt = ST_SETUP;
          end else if (in_last_sample) begin
            pend_peak_nxt  = '0;
            pend_short_nxt = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            // first sample of a run: only held
            p1_nxt  = cur_nxt;
            pdt_nxt = in_interval_us;
            pos_nxt = POS_ONE;
          end
        end
      end
      ST_SETUP: begin
        for (int i = 0; i < 4; i++) begin
          if (job_r == JOB_LAST) begin
            q_nxt[i] = cur_r[i];
            d_nxt[i] = DW'(cur_r[i]) - DW'(p1_r[i]);
          end else begin
            q_nxt[i] = p1_r[i];
            d_nxt[i] = DW'(cur_r[i]) -
                       ((pos_r == POS_MANY) ? DW'(p2_r[i]) : DW'(p1_r[i]));
          end
        end
        den_nxt = (job_r == JOB_HELD && pos_r == POS_MANY) ? {dt_nz[DW-2:0], 1'b0} : dt_nz;
        cnt_nxt = '0;
        acc_nxt = '0;
        state_nxt = ST_MAC;
      end
      ST_MAC: begin
        if (term.neg) acc_nxt = acc_r - (VW+1)'(mul_p);
        else          acc_nxt = acc_r + (VW+1)'(mul_p);
        if (cnt_r[1:0] == 2'd3) begin
          v_nxt[cnt_r[3:2]] = acc_nxt[VW-1:0];
          acc_nxt = '0;
        end
        if (cnt_r[3:0] == 4'(MAC_TERMS - 1)) begin
          cnt_nxt = '0;
          n_nxt = '0;
          state_nxt = ST_SQ;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      ST_SQ: begin
        n_nxt = n_r + mul_p[63:0];
        if (cnt_r[1:0] == 2'd2) begin
          cnt_nxt = '0;
          res_nxt = '0;
          bit_nxt = 64'd1 << 62;
          state_nxt = ST_SQRT;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      ST_SQRT: begin
        if (n_r >= trial) begin
          n_nxt   = n_r - trial;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (cnt_r[4:0] == 5'(SQRT_STEPS - 1)) begin
          cnt_nxt = '0;
          state_nxt = ST_SCALE;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      ST_SCALE: begin
        num_nxt = mul_p[SCALE_SHIFT +: NW];
        rem_nxt = '0;
        cnt_nxt = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (rem_sh >= {1'b0, den_r}) begin
          rem_nxt = DW'(rem_sh - {1'b0, den_r});
          num_nxt = {num_r[NW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[DW-1:0];
          num_nxt = {num_r[NW-2:0], 1'b0};
        end
        if (cnt_r == 6'(NW - 1)) begin
          cnt_nxt = '0;
          state_nxt = ST_DONE;
          job_nxt = job_r;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
        if (cnt_r == 6'(NW - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: ;
      default: state_nxt = ST_IDLE;
    endcase

    // Closing: DONE after DIV folds the rate in; DONE with a pending
    // result hands it to the output register.
    if (state_r == ST_DIV && cnt_r == 6'(NW - 1)) begin
      state_nxt = ST_DONE;
      pend_short_nxt = 1'b0;
    end
  end

  // Rate fold and result hand-off, kept apart from the sequencer above
  logic        fold_r, fold_nxt;
  logic [PW-1:0] peak_upd;
  assign fold_nxt = (state_r == ST_DIV) && (cnt_r == 6'(NW - 1));
  assign peak_upd = (rate_sat > peak_r) ? rate_sat : peak_r;

  logic [2:0]  state_fin;
  logic [1:0]  pos_fin;
  logic        job_fin;
  logic [PW-1:0] peak_fin, pend_peak_fin, out_peak_fin;
  logic        pend_short_fin, out_short_fin, out_valid_fin;
  logic signed [QW-1:0] p1_fin [4];
  logic signed [QW-1:0] p2_fin [4];
  logic [TW-1:0] pdt_fin, p2dt_fin;

  always_comb begin
    state_fin = state_nxt;  pos_fin = pos_nxt;  job_fin = job_nxt;
    peak_fin = peak_nxt;    pend_peak_fin = pend_peak_nxt;
    pend_short_fin = pend_short_nxt;
    out_peak_fin = out_peak_nxt;  out_short_fin = out_short_nxt;
    out_valid_fin = out_valid_nxt;
    p1_fin = p1_nxt;  p2_fin = p2_nxt;  pdt_fin = pdt_nxt;  p2dt_fin = p2dt_nxt;
    if (state_r == ST_DONE) begin
      if (fold_r) begin
        if (job_r == JOB_HELD && last_r) begin
          peak_fin  = peak_upd;
          job_fin   = JOB_LAST;
          state_fin = ST_SETUP;
        end else if (last_r) begin
          pend_peak_fin  = peak_upd;
          pend_short_fin = 1'b0;
          peak_fin  = '0;
          pos_fin   = POS_START;
          state_fin = ST_DONE;
        end else begin
          peak_fin = peak_upd;
          p2_fin   = p1_r;
          p1_fin   = cur_r;
          p2dt_fin = pdt_r;
          pdt_fin  = dt_r;
          pos_fin  = POS_MANY;
          state_fin = ST_IDLE;
        end
      end else if (!out_valid_r || !out_stall) begin
        out_valid_fin = 1'b1;
        out_peak_fin  = pend_peak_r;
        out_short_fin = pend_short_r;
        peak_fin  = '0;
        pos_fin   = POS_START;
        for (int i = 0; i < 4; i++) begin
          p1_fin[i] = '0;
          p2_fin[i] = '0;
        end
        pdt_fin   = '0;
        p2dt_fin  = '0;
        state_fin = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= POS_START;
      job_r       <= JOB_HELD;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
      fold_r      <= 1'b0;
      pdt_r       <= '0;
      p2dt_r      <= '0;
      for (int i = 0; i < 4; i++) begin
        p1_r[i] <= '0;
        p2_r[i] <= '0;
      end
    end else begin
      state_r     <= state_fin;
      pos_r       <= pos_fin;
      job_r       <= job_fin;
      peak_r      <= peak_fin;
      out_valid_r <= out_valid_fin;
      fold_r      <= fold_nxt;
      pdt_r       <= pdt_fin;
      p2dt_r      <= p2dt_fin;
      p1_r        <= p1_fin;
      p2_r        <= p2_fin;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    dt_r    <= dt_nxt;
    last_r  <= last_nxt;
    q_r     <= q_nxt;
    d_r     <= d_nxt;
    den_r   <= den_nxt;
    cnt_r   <= cnt_nxt;
    acc_r   <= acc_nxt;
    v_r     <= v_nxt;
    n_r     <= n_nxt;
    res_r   <= res_nxt;
    bit_r   <= bit_nxt;
    num_r   <= num_nxt;
    rem_r   <= rem_nxt;
    out_peak_r   <= out_peak_fin;
    out_short_r  <= out_short_fin;
    pend_peak_r  <= pend_peak_fin;
    pend_short_r <= pend_short_fin;
  end

endmodule
`default_nettype wire
